// ----- rtl/pbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared types, factor codes and helpers for the pixel blend factor unit.
// ----------------------------------------------------------------------------
package pbf_pkg;

	localparam int ChanW   = 8;
	localparam int NumChan = 4;
	localparam int PixW    = ChanW * NumChan;
	localparam int ProdW   = 2 * ChanW;
	localparam int SumW    = ProdW + 1;
	localparam int CfgIdxW = 2;
	localparam int CfgW    = 4;
	localparam int AlphaCh = NumChan - 1;

	// Register indexes
	localparam logic [CfgIdxW-1:0] CFG_BLEND_ON   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_SRC_FACTOR = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_DST_FACTOR = 2'd2;

	// Factor codes; anything above FAC_INVDSTALPHA means one
	localparam logic [CfgW-1:0] FAC_ZERO        = 4'd0;
	localparam logic [CfgW-1:0] FAC_ONE         = 4'd1;
	localparam logic [CfgW-1:0] FAC_SRCCOL      = 4'd2;
	localparam logic [CfgW-1:0] FAC_INVSRCCOL   = 4'd3;
	localparam logic [CfgW-1:0] FAC_SRCALPHA    = 4'd4;
	localparam logic [CfgW-1:0] FAC_INVSRCALPHA = 4'd5;
	localparam logic [CfgW-1:0] FAC_DSTCOL      = 4'd6;
	localparam logic [CfgW-1:0] FAC_INVDSTCOL   = 4'd7;
	localparam logic [CfgW-1:0] FAC_DSTALPHA    = 4'd8;
	localparam logic [CfgW-1:0] FAC_INVDSTALPHA = 4'd9;

	localparam logic [ChanW-1:0] ChanMax = 8'hff;

	// floor(x/255) = (x * DivRecip) >> DivShift, exact for x < SatLimit
	localparam logic [ProdW-1:0] DivRecip = 16'h8081;
	localparam int               DivShift = 23;
	// 255*256: at or above this the quotient saturates
	localparam logic [SumW-1:0]  SatLimit = 17'd65280;

	typedef logic [ChanW-1:0] chan_t;
	typedef chan_t [NumChan-1:0] chan_vec_t;
	typedef logic [ProdW-1:0] prod_t;
	typedef prod_t [NumChan-1:0] prod_vec_t;

	typedef struct packed {
		logic            blend_on;
		logic [CfgW-1:0] src_code;
		logic [CfgW-1:0] dst_code;
	} cfg_t;

	function automatic chan_t pick_factor(
		input logic [CfgW-1:0] code,
		input chan_t           s_c,
		input chan_t           s_a,
		input chan_t           d_c,
		input chan_t           d_a
	);
		chan_t f;
		case (code)
			FAC_ZERO:        f = '0;
			FAC_SRCCOL:      f = s_c;
			FAC_INVSRCCOL:   f = ChanMax - s_c;
			FAC_SRCALPHA:    f = s_a;
			FAC_INVSRCALPHA: f = ChanMax - s_a;
			FAC_DSTCOL:      f = d_c;
			FAC_INVDSTCOL:   f = ChanMax - d_c;
			FAC_DSTALPHA:    f = d_a;
			FAC_INVDSTALPHA: f = ChanMax - d_a;
			default:         f = ChanMax;
		endcase
		return f;
	endfunction

endpackage

// ----- rtl/pbf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_in_if / pbf_out_if
// Valid/ready channels for pixel pairs in and blended pixels out.
// ----------------------------------------------------------------------------
interface pbf_in_if;
	logic                      valid;
	logic                      ready;
	logic [pbf_pkg::PixW-1:0] source_pixel;
	logic [pbf_pkg::PixW-1:0] dst_pixel;

	modport source (output valid, output source_pixel, output dst_pixel, input ready);
	modport sink   (input valid, input source_pixel, input dst_pixel, output ready);
endinterface

interface pbf_out_if;
	logic                      valid;
	logic                      ready;
	logic [pbf_pkg::PixW-1:0] blended_pixel;

	modport source (output valid, output blended_pixel, input ready);
	modport sink   (input valid, input blended_pixel, output ready);
endinterface

// ----- rtl/pbf_factor_sel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_factor_sel
// Stage 1: registers the pixel pair and the per-channel factors.
// ----------------------------------------------------------------------------
module pbf_factor_sel (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid_in,
	input  logic [pbf_pkg::PixW-1:0] source_pixel,
	input  logic [pbf_pkg::PixW-1:0] dst_pixel,
	input  pbf_pkg::cfg_t            cfg,
	output logic                      valid_s1,
	output logic                      blend_s1,
	output pbf_pkg::chan_vec_t        src_s1,
	output pbf_pkg::chan_vec_t        dst_s1,
	output pbf_pkg::chan_vec_t        fs_s1,
	output pbf_pkg::chan_vec_t        fd_s1
);

	pbf_pkg::chan_vec_t src_c, dst_c, fs_c, fd_c;

	assign src_c = pbf_pkg::chan_vec_t'(source_pixel);
	assign dst_c = pbf_pkg::chan_vec_t'(dst_pixel);

	always_comb begin
		for (int k = 0; k < pbf_pkg::NumChan; k++) begin
			fs_c[k] = pbf_pkg::pick_factor(cfg.src_code, src_c[k],
				src_c[pbf_pkg::AlphaCh], dst_c[k], dst_c[pbf_pkg::AlphaCh]);
			fd_c[k] = pbf_pkg::pick_factor(cfg.dst_code, src_c[k],
				src_c[pbf_pkg::AlphaCh], dst_c[k], dst_c[pbf_pkg::AlphaCh]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blend_s1 <= cfg.blend_on;
			src_s1   <= src_c;
			dst_s1   <= dst_c;
			fs_s1    <= fs_c;
			fd_s1    <= fd_c;
		end
	end

endmodule

// ----- rtl/pbf_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_mac
// Stages 2 and 3: channel products, then their sum and saturation flag.
// ----------------------------------------------------------------------------
module pbf_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid_s1,
	input  logic                      blend_s1,
	input  pbf_pkg::chan_vec_t        src_s1,
	input  pbf_pkg::chan_vec_t        dst_s1,
	input  pbf_pkg::chan_vec_t        fs_s1,
	input  pbf_pkg::chan_vec_t        fd_s1,
	output logic                      valid_s3,
	output logic                      blend_s3,
	output pbf_pkg::chan_vec_t        src_s3,
	output pbf_pkg::prod_vec_t        sum_s3,
	output logic [pbf_pkg::NumChan-1:0] sat_s3
);

	logic                valid_s2, blend_s2;
	pbf_pkg::chan_vec_t  src_s2;
	pbf_pkg::prod_vec_t  ps_s2, pd_s2;
	logic [pbf_pkg::SumW-1:0] sum_c [pbf_pkg::NumChan];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		for (int k = 0; k < pbf_pkg::NumChan; k++) begin
			sum_c[k] = {1'b0, ps_s2[k]} + {1'b0, pd_s2[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blend_s2 <= blend_s1;
			src_s2   <= src_s1;
			for (int k = 0; k < pbf_pkg::NumChan; k++) begin
				ps_s2[k] <= pbf_pkg::prod_t'(src_s1[k]) * pbf_pkg::prod_t'(fs_s1[k]);
				pd_s2[k] <= pbf_pkg::prod_t'(dst_s1[k]) * pbf_pkg::prod_t'(fd_s1[k]);
			end
			blend_s3 <= blend_s2;
			src_s3   <= src_s2;
			for (int k = 0; k < pbf_pkg::NumChan; k++) begin
				sum_s3[k] <= sum_c[k][pbf_pkg::ProdW-1:0];
				sat_s3[k] <= (sum_c[k] >= pbf_pkg::SatLimit);
			end
		end
	end

endmodule

// ----- rtl/pbf_div255.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_div255
// Stage 4: divide by 255 via reciprocal multiply, saturate, pass-through mux.
// ----------------------------------------------------------------------------
module pbf_div255 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_s3,
	input  logic                        blend_s3,
	input  pbf_pkg::chan_vec_t          src_s3,
	input  pbf_pkg::prod_vec_t          sum_s3,
	input  logic [pbf_pkg::NumChan-1:0] sat_s3,
	output logic                        valid_s4,
	output logic [pbf_pkg::PixW-1:0]   pixel_s4
);

	logic [2*pbf_pkg::ProdW-1:0] recip_c [pbf_pkg::NumChan];
	pbf_pkg::chan_vec_t          res_c;

	always_comb begin
		for (int k = 0; k < pbf_pkg::NumChan; k++) begin
			recip_c[k] = (2*pbf_pkg::ProdW)'(sum_s3[k])
				* (2*pbf_pkg::ProdW)'(pbf_pkg::DivRecip);
			res_c[k]   = sat_s3[k] ? pbf_pkg::ChanMax
				: recip_c[k][pbf_pkg::DivShift +: pbf_pkg::ChanW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_s4 <= blend_s3 ? pbf_pkg::PixW'(res_c) : pbf_pkg::PixW'(src_s3);
		end
	end

endmodule

// ----- rtl/pixel_blend_factor_unit.sv -----
`timescale 1ns / 1ps
// Path: an accepted input beat passes the registers of stages 1 to 4 to the output.
// Throughput: one pixel pair per cycle; the pipeline halts as a whole
// only while the output register holds a beat that is not taken.
// Reset: arst_n clears all stage valid bits and loads blend_on = 0,
// source_factor = one, dest_factor = zero. Payload registers are not reset.
// ----------------------------------------------------------------------------
// pixel_blend_factor_unit
// Four-stage RGBA8888 blend: factor select, multiply, sum, divide by 255.
// ----------------------------------------------------------------------------
module pixel_blend_factor_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	pbf_in_if.sink                           pix_in,
	pbf_out_if.source                        pix_out,
	input  logic                             cfg_we,
	input  logic [pbf_pkg::CfgIdxW-1:0]      cfg_idx,
	input  logic [pbf_pkg::CfgW-1:0]         cfg_data
);

	// Config registers; must be only written while the pipe is drained (user's duty, not enforced)
	logic                       blend_on_q;
	logic [pbf_pkg::CfgW-1:0]   src_factor_q;
	logic [pbf_pkg::CfgW-1:0]   dst_factor_q;
	pbf_pkg::cfg_t              cfg;

	// Global advance: every stage moves when the output slot is free or drains
	logic en;

	logic                        valid_s1, blend_s1;
	pbf_pkg::chan_vec_t          src_s1, dst_s1, fs_s1, fd_s1;
	logic                        valid_s3, blend_s3;
	pbf_pkg::chan_vec_t          src_s3;
	pbf_pkg::prod_vec_t          sum_s3;
	logic [pbf_pkg::NumChan-1:0] sat_s3;
	logic                        valid_s4;
	logic [pbf_pkg::PixW-1:0]    pixel_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_on_q   <= 1'b0;
			src_factor_q <= pbf_pkg::FAC_ONE;
			dst_factor_q <= pbf_pkg::FAC_ZERO;
		end else if (cfg_we) begin
			case (cfg_idx)
				pbf_pkg::CFG_BLEND_ON:   blend_on_q   <= cfg_data[0];
				pbf_pkg::CFG_SRC_FACTOR: src_factor_q <= cfg_data;
				pbf_pkg::CFG_DST_FACTOR: dst_factor_q <= cfg_data;
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	assign cfg.blend_on = blend_on_q;
	assign cfg.src_code = src_factor_q;
	assign cfg.dst_code = dst_factor_q;

	// The output register is the skid point: a new beat enters whenever the
	// last stage can hand its beat on this same edge.
	assign en           = !valid_s4 || pix_out.ready;
	assign pix_in.ready = en;

	// Stage 1: capture pixels, pick Fs/Fd per channel
	pbf_factor_sel u_sel (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.valid_in     (pix_in.valid),
		.source_pixel (pix_in.source_pixel),
		.dst_pixel    (pix_in.dst_pixel),
		.cfg          (cfg),
		.valid_s1     (valid_s1),
		.blend_s1     (blend_s1),
		.src_s1       (src_s1),
		.dst_s1       (dst_s1),
		.fs_s1        (fs_s1),
		.fd_s1        (fd_s1)
	);

	// Stages 2-3: 8x8 products, then 17-bit sum with saturation flag
	pbf_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.blend_s1 (blend_s1),
		.src_s1   (src_s1),
		.dst_s1   (dst_s1),
		.fs_s1    (fs_s1),
		.fd_s1    (fd_s1),
		.valid_s3 (valid_s3),
		.blend_s3 (blend_s3),
		.src_s3   (src_s3),
		.sum_s3   (sum_s3),
		.sat_s3   (sat_s3)
	);

	// Stage 4: /255 by reciprocal multiply; blend off selects the source
	pbf_div255 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s3 (valid_s3),
		.blend_s3 (blend_s3),
		.src_s3   (src_s3),
		.sum_s3   (sum_s3),
		.sat_s3   (sat_s3),
		.valid_s4 (valid_s4),
		.pixel_s4 (pixel_s4)
	);

	assign pix_out.valid         = valid_s4;
	assign pix_out.blended_pixel = pixel_s4;

endmodule

// ----- rtl/pbf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_checker
// Port-level checks on the blend unit handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module pbf_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [pbf_pkg::PixW-1:0] out_pixel
);

	// Held output beat keeps its data
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_pixel)))
		else $error("output beat changed while stalled");

	// Input side is open exactly when the output slot can move
	ast_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready disagrees with output slot");

	// A new output beat only after the pipe advanced
	ast_rose_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("output valid rose without pipeline advance");

	// An accepted beat reaches the output while the output side keeps taking beats
	ast_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid)
		else $error("accepted beat did not arrive after four cycles");

endmodule

bind pixel_blend_factor_unit pbf_checker u_pbf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_pixel (pix_out.blended_pixel)
);
